// ===== src/cfh_pkg.sv =====
// Shared types, constants and helpers for the charge field heat map.
// Used by cfh_in_if, the controller, the datapath and the top level.
// Has no dependencies.
package cfh_pkg;

	localparam int MaxCharges = 1024;
	localparam int SlotBits   = 10;
	localparam int CoordBits  = 12;
	localparam int CountBits  = 11;

	// Offset of 0.01 in units of 2^-12.
	localparam logic [25:0] OffsetQ12  = 26'd41;
	localparam logic [10:0] ColorSteps = 11'd1149;

	localparam logic [10:0] BandBlue   = 11'd255;
	localparam logic [10:0] BandGreen  = 11'd510;
	localparam logic [10:0] BandYellow = 11'd765;
	localparam logic [10:0] BandRed    = 11'd1020;
	localparam logic [10:0] BandDark   = 11'd1276;
	localparam logic [10:0] ColorFull  = 11'd255;
	localparam logic [10:0] ColorHalf  = 11'd127;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_MEASURE = 2'd1,
		MODE_COLOR   = 2'd2,
		MODE_FRAME   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_FIELD_K  = 2'd0,
		REG_IN_USE   = 2'd1,
		REG_TOP_FRAC = 2'd2,
		REG_BOT_FRAC = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DV_T1,
		DV_T2,
		DV_LV
	} dv_sel_t;

	typedef struct packed {
		logic                take;
		logic                mem_wr;
		logic                mem_rd;
		logic [SlotBits-1:0] addr;
		logic                calc_d;
		logic                sq_start;
		logic                sq_final;
		logic                mul_k;
		logic                dv_start;
		dv_sel_t             dv_sel;
		logic                acc;
		logic                fin_sq;
		logic                f_load;
		logic                col_mul;
		logic                finish;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  sq_done;
		logic  dv_done;
		logic  col_ok;
		logic  out_full;
	} stat_t;

	// Six-band heat map; a level past the last band stays dark red.
	function automatic logic [23:0] heat_rgb(input logic [42:0] lv);
		logic [10:0] l;
		logic [10:0] r;
		logic [10:0] g;
		logic [10:0] b;
		l = lv[10:0];
		r = '0;
		g = '0;
		b = '0;
		if (lv > {32'b0, ColorSteps}) begin
			r = ColorHalf;
		end else if (l <= BandBlue) begin
			b = l;
		end else if (l <= BandGreen) begin
			g = l - BandBlue;
			b = ColorFull;
		end else if (l <= BandYellow) begin
			r = l - BandGreen;
			g = ColorFull;
			b = BandYellow - l;
		end else if (l <= BandRed) begin
			r = ColorFull;
			g = BandRed - l;
		end else begin
			r = BandDark - l;
		end
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

endpackage

// ===== src/cfh_in_if.sv =====
// Input channel of the heat map: one word per charge load, pixel or frame start.
// Depends on cfh_pkg.
interface cfh_in_if;
	import cfh_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           mode;
	logic [SlotBits-1:0]  charge_slot;
	logic [CoordBits-1:0] pos_x;
	logic [CoordBits-1:0] pos_y;

	modport source(output valid, output mode, output charge_slot, output pos_x,
		output pos_y, input ready);
	modport sink(input valid, input mode, input charge_slot, input pos_x,
		input pos_y, output ready);
endinterface

// ===== src/cfh_out_if.sv =====
// Output channel of the heat map: one result word per input word.
// No dependencies.
interface cfh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] intensity;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	modport source(output valid, output intensity, output red, output green,
		output blue, input ready);
	modport sink(input valid, input intensity, input red, input green,
		input blue, output ready);
endinterface

// ===== src/charge_field_heatmap_top.sv =====
// Top level of the charge field heat map: configuration registers, controller
// and datapath. Depends on cfh_pkg, cfh_in_if, cfh_out_if, cfh_ctrl and cfh_dp.
//
// Words arrive on in_ch and each one gives exactly one word on out_ch.
// A load word writes one charge into the 1024-entry table; a frame-start word
// clears the peak; both return zero. A measure word sums the field of the
// first charges_in_use charges (at most 1024) at the pixel and updates the
// peak; a color word does the same sum and maps it to a heat-map color. Per
// charge the 32-step root runs, then the x and y bit-serial 64-step dividers
// twice, side by side. A pixel word then takes a final root, and in color
// mode may add a level division. One word is worked on at a time; in_ch.ready
// is high only when idle. The result waits in an output register; if out_ch
// stalls, the block holds it and may work on the next word, but does not
// finish that word until the result is taken. Reset clears the controller,
// the peak and the output valid, and loads the register defaults; the charge
// table is not cleared and must be loaded before it is summed. Registers are
// to be written over the APB port while idle; the block does not enforce it.
module charge_field_heatmap_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	cfh_in_if.sink      in_ch,
	cfh_out_if.source   out_ch
);
	import cfh_pkg::*;

	logic [15:0]          k_q;
	logic [CountBits-1:0] cuse_q;
	logic [15:0]          tf_q;
	logic [15:0]          bf_q;
	logic                 wr_en;
	reg_idx_t             ridx;
	cmd_t                 cmd;
	stat_t                stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign ridx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= 16'd100;
			cuse_q <= CountBits'(MaxCharges);
			tf_q   <= 16'd6554;
			bf_q   <= 16'd0;
		end else if (wr_en) begin
			case (ridx)
				REG_FIELD_K:  k_q    <= pwdata[15:0];
				REG_IN_USE:   cuse_q <= pwdata[CountBits-1:0];
				REG_TOP_FRAC: tf_q   <= pwdata[15:0];
				REG_BOT_FRAC: bf_q   <= pwdata[15:0];
				default:      k_q    <= k_q;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_FIELD_K:  prdata = {16'b0, k_q};
			REG_IN_USE:   prdata = {21'b0, cuse_q};
			REG_TOP_FRAC: prdata = {16'b0, tf_q};
			REG_BOT_FRAC: prdata = {16'b0, bf_q};
			default:      prdata = '0;
		endcase
	end

	cfh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.charges_in_use(cuse_q),
		.stat          (stat),
		.cmd           (cmd)
	);

	cfh_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (in_ch.mode),
		.charge_slot    (in_ch.charge_slot),
		.pos_x          (in_ch.pos_x),
		.pos_y          (in_ch.pos_y),
		.field_constant (k_q),
		.top_fraction   (tf_q),
		.bottom_fraction(bf_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.intensity      (out_ch.intensity),
		.red            (out_ch.red),
		.green          (out_ch.green),
		.blue           (out_ch.blue)
	);
endmodule

// ===== src/cfh_sqrt.sv =====
// Bit-serial integer square root of a 64-bit radicand, two radicand bits a cycle.
// No dependencies.
module cfh_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic [31:0] root,
	output logic        done
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] rem_next;
	logic [33:0] trial;
	logic        ge;

	assign rem_next = {rem_q[31:0], rad_q[63:62]};
	assign trial    = {root_q, 2'b01};
	assign ge       = rem_next >= trial;
	assign root     = root_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? rem_next - trial : rem_next;
			root_q <= {root_q[30:0], ge};
		end
	end
endmodule

// ===== src/cfh_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// No dependencies.
module cfh_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [63:0] quo,
	output logic        done
);
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_next;
	logic        ge;

	assign rem_next = {rem_q[31:0], num_q[63]};
	assign ge       = rem_next >= {1'b0, den_q};
	assign quo      = num_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The dividend register fills up with quotient bits from the right.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], ge};
			rem_q <= ge ? rem_next - {1'b0, den_q} : rem_next;
		end
	end
endmodule

// ===== src/cfh_dp.sv =====
// Datapath of the heat map: charge table, distance root, term dividers, sums,
// output register and peak. Depends on cfh_pkg, cfh_sqrt and cfh_div.
module cfh_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfh_pkg::cmd_t                 cmd,
	output cfh_pkg::stat_t                stat,
	input  logic [1:0]                    mode,
	input  logic [cfh_pkg::SlotBits-1:0]  charge_slot,
	input  logic [cfh_pkg::CoordBits-1:0] pos_x,
	input  logic [cfh_pkg::CoordBits-1:0] pos_y,
	input  logic [15:0]                   field_constant,
	input  logic [15:0]                   top_fraction,
	input  logic [15:0]                   bottom_fraction,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   intensity,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);
	import cfh_pkg::*;

	logic [2*CoordBits-1:0] mem [MaxCharges];
	logic [2*CoordBits-1:0] rd_q;

	mode_t                mode_q;
	logic [SlotBits-1:0]  slot_q;
	logic [CoordBits-1:0] px_q;
	logic [CoordBits-1:0] py_q;
	logic [CoordBits-1:0] ax_q;
	logic [CoordBits-1:0] ay_q;
	logic [25:0]          m_q;
	logic [27:0]          kx_q;
	logic [27:0]          ky_q;
	logic [31:0]          sx_q;
	logic [31:0]          sy_q;
	logic [63:0]          sqx_q;
	logic [63:0]          sqy_q;
	logic [31:0]          f_q;
	logic [31:0]          bot_q;
	logic [31:0]          top_q;
	logic [31:0]          peak_q;
	logic                 out_valid_q;

	logic [CoordBits-1:0] col;
	logic [CoordBits-1:0] row;
	logic [CoordBits-1:0] ax;
	logic [CoordBits-1:0] ay;
	logic [24:0]          dsq;
	logic [64:0]          fin_sum;
	logic [63:0]          sq_rad;
	logic [31:0]          sq_root;
	logic                 sq_done;
	logic [63:0]          numx;
	logic [63:0]          numy;
	logic [31:0]          denx;
	logic [63:0]          qx;
	logic [63:0]          qy;
	logic                 dx_done;
	logic                 dy_done;
	logic [31:0]          dfb;
	logic [42:0]          lv_num;
	logic [47:0]          bot_full;
	logic [47:0]          top_full;
	logic [16:0]          top_keep;
	logic [32:0]          sx_next;
	logic [32:0]          sy_next;
	logic                 col_ok;
	logic [23:0]          rgb;

	assign col = rd_q[2*CoordBits-1:CoordBits];
	assign row = rd_q[CoordBits-1:0];
	assign ax  = (px_q >= col) ? px_q - col : col - px_q;
	assign ay  = (py_q >= row) ? py_q - row : row - py_q;
	assign dsq = {13'b0, ax_q} * {13'b0, ax_q} + {13'b0, ay_q} * {13'b0, ay_q};

	// A sum of squares past 64 bits saturates; its root is then all ones as well.
	assign fin_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign sq_rad  = cmd.sq_final ? (fin_sum[64] ? '1 : fin_sum[63:0])
		: {15'b0, dsq, 24'b0};

	assign dfb      = f_q - bot_q;
	assign lv_num   = {11'b0, dfb} * {32'b0, ColorSteps};
	assign top_keep = 17'h10000 - {1'b0, top_fraction};
	assign bot_full = {16'b0, peak_q} * {32'b0, bottom_fraction};
	assign top_full = {16'b0, peak_q} * {31'b0, top_keep};
	assign col_ok   = (top_q > bot_q) && (f_q > bot_q);

	always_comb begin
		case (cmd.dv_sel)
			DV_T1: begin
				numx = {12'b0, kx_q, 24'b0};
				numy = {12'b0, ky_q, 24'b0};
				denx = {6'b0, m_q};
			end
			DV_T2: begin
				numx = {qx[51:0], 12'b0};
				numy = {qy[51:0], 12'b0};
				denx = {6'b0, m_q};
			end
			DV_LV: begin
				numx = {21'b0, lv_num};
				numy = '0;
				denx = top_q - bot_q;
			end
			default: begin
				numx = '0;
				numy = '0;
				denx = {6'b0, m_q};
			end
		endcase
	end

	assign sx_next = {1'b0, sx_q} + {4'b0, qx[28:0]};
	assign sy_next = {1'b0, sy_q} + {4'b0, qy[28:0]};
	assign rgb     = heat_rgb(qx[42:0]);

	cfh_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.sq_start),
		.rad   (sq_rad),
		.root  (sq_root),
		.done  (sq_done)
	);

	cfh_div u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.dv_start),
		.num   (numx),
		.den   (denx),
		.quo   (qx),
		.done  (dx_done)
	);

	cfh_div u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.dv_start && (cmd.dv_sel != DV_LV)),
		.num   (numy),
		.den   ({6'b0, m_q}),
		.quo   (qy),
		.done  (dy_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[slot_q] <= {px_q, py_q};
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[cmd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= mode_t'(mode);
			slot_q <= charge_slot;
			px_q   <= pos_x;
			py_q   <= pos_y;
			sx_q   <= '0;
			sy_q   <= '0;
		end
		if (cmd.calc_d) begin
			ax_q <= ax;
			ay_q <= ay;
		end
		if (cmd.mul_k) begin
			m_q  <= {1'b0, sq_root[24:0]} + OffsetQ12;
			kx_q <= {16'b0, ax_q} * {12'b0, field_constant};
			ky_q <= {16'b0, ay_q} * {12'b0, field_constant};
		end
		if (cmd.acc) begin
			sx_q <= sx_next[32] ? '1 : sx_next[31:0];
			sy_q <= sy_next[32] ? '1 : sy_next[31:0];
		end
		if (cmd.fin_sq) begin
			sqx_q <= {32'b0, sx_q} * {32'b0, sx_q};
			sqy_q <= {32'b0, sy_q} * {32'b0, sy_q};
		end
		if (cmd.f_load) begin
			f_q <= sq_root;
		end
		if (cmd.col_mul) begin
			bot_q <= bot_full[47:16];
			top_q <= top_full[47:16];
		end
		if (cmd.finish) begin
			if (mode_q == MODE_MEASURE || mode_q == MODE_COLOR) begin
				intensity <= f_q;
			end else begin
				intensity <= '0;
			end
			if (mode_q == MODE_COLOR && col_ok) begin
				{red, green, blue} <= rgb;
			end else begin
				{red, green, blue} <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (mode_q == MODE_FRAME) begin
					peak_q <= '0;
				end else if (mode_q == MODE_MEASURE && f_q > peak_q) begin
					peak_q <= f_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.mode     = mode_q;
	assign stat.sq_done  = sq_done;
	// The level division runs on the x divider alone.
	assign stat.dv_done  = dx_done && (dy_done || cmd.dv_sel == DV_LV);
	assign stat.col_ok   = col_ok;
	assign stat.out_full = out_valid_q;
endmodule

// ===== src/cfh_ctrl.sv =====
// Controller of the heat map: sequences each word through the datapath and
// walks the charge table for pixel words. Depends on cfh_pkg.
module cfh_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cfh_pkg::CountBits-1:0] charges_in_use,
	input  cfh_pkg::stat_t                stat,
	output cfh_pkg::cmd_t                 cmd
);
	import cfh_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD,
		S_CALC,
		S_SQ_GO,
		S_SQ_WAIT,
		S_MK,
		S_DV1,
		S_DV1_WAIT,
		S_DV2,
		S_DV2_WAIT,
		S_ACC,
		S_FIN_SQ,
		S_FIN_GO,
		S_FIN_WAIT,
		S_COL_MUL,
		S_COL_CHK,
		S_COL_WAIT,
		S_RES
	} state_t;

	state_t               state_q;
	logic [CountBits-1:0] idx_q;
	logic [CountBits-1:0] n_use;
	logic [CountBits-1:0] idx_inc;

	assign n_use    = (charges_in_use > CountBits'(MaxCharges))
		? CountBits'(MaxCharges) : charges_in_use;
	assign idx_inc  = idx_q + 1'b1;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.addr   = idx_q[SlotBits-1:0];
		cmd.dv_sel = DV_T1;
		case (state_q)
			S_IDLE:     cmd.take = in_valid;
			S_DISPATCH: cmd.mem_wr = (stat.mode == MODE_LOAD);
			S_RD:       cmd.mem_rd = 1'b1;
			S_CALC:     cmd.calc_d = 1'b1;
			S_SQ_GO:    cmd.sq_start = 1'b1;
			S_MK:       cmd.mul_k = 1'b1;
			S_DV1:      cmd.dv_start = 1'b1;
			S_DV2: begin
				cmd.dv_start = 1'b1;
				cmd.dv_sel   = DV_T2;
			end
			S_ACC:      cmd.acc = 1'b1;
			S_FIN_SQ:   cmd.fin_sq = 1'b1;
			S_FIN_GO: begin
				cmd.sq_start = 1'b1;
				cmd.sq_final = 1'b1;
			end
			S_FIN_WAIT: cmd.f_load = stat.sq_done;
			S_COL_MUL:  cmd.col_mul = 1'b1;
			S_COL_CHK: begin
				cmd.dv_start = stat.col_ok;
				cmd.dv_sel   = DV_LV;
			end
			S_COL_WAIT: cmd.dv_sel = DV_LV;
			S_RES:      cmd.finish = !stat.out_full;
			default:    cmd.take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					idx_q <= '0;
					if (stat.mode == MODE_MEASURE || stat.mode == MODE_COLOR) begin
						state_q <= (n_use == '0) ? S_FIN_SQ : S_RD;
					end else begin
						state_q <= S_RES;
					end
				end
				S_RD:      state_q <= S_CALC;
				S_CALC:    state_q <= S_SQ_GO;
				S_SQ_GO:   state_q <= S_SQ_WAIT;
				S_SQ_WAIT: begin
					if (stat.sq_done) begin
						state_q <= S_MK;
					end
				end
				S_MK:      state_q <= S_DV1;
				S_DV1:     state_q <= S_DV1_WAIT;
				S_DV1_WAIT: begin
					if (stat.dv_done) begin
						state_q <= S_DV2;
					end
				end
				S_DV2:     state_q <= S_DV2_WAIT;
				S_DV2_WAIT: begin
					if (stat.dv_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (idx_inc >= n_use) begin
						state_q <= S_FIN_SQ;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_RD;
					end
				end
				S_FIN_SQ:  state_q <= S_FIN_GO;
				S_FIN_GO:  state_q <= S_FIN_WAIT;
				S_FIN_WAIT: begin
					if (stat.sq_done) begin
						state_q <= (stat.mode == MODE_COLOR) ? S_COL_MUL : S_RES;
					end
				end
				S_COL_MUL: state_q <= S_COL_CHK;
				S_COL_CHK: state_q <= stat.col_ok ? S_COL_WAIT : S_RES;
				S_COL_WAIT: begin
					if (stat.dv_done) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (!stat.out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sim/charge_field_heatmap_top_tb.sv =====
// Self-checking testbench for the charge field heat map top level.
// Depends on cfh_pkg, cfh_in_if, cfh_out_if and charge_field_heatmap_top.
module charge_field_heatmap_top_tb;
	import cfh_pkg::*;

	localparam int CycleLimit = 8000000;

	typedef struct {
		mode_t      mode;
		logic [9:0]  slot;
		logic [11:0] x;
		logic [11:0] y;
	} pixel_word_t;

	typedef struct {
		logic [31:0] intensity;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} heat_word_t;

	class heat_scoreboard;
		bit [15:0] k_const;
		bit [10:0] n_use;
		bit [15:0] top_cut;
		bit [15:0] bot_floor;
		bit [11:0] col_tab[MaxCharges];
		bit [11:0] row_tab[MaxCharges];
		longint unsigned peak;
		heat_word_t pending[$];
		int errors;
		int checked;
		int mode_count[4];

		function new();
			k_const = 16'd100;
			n_use = 11'd1024;
			top_cut = 16'd6554;
			bot_floor = 16'd0;
			peak = 0;
			errors = 0;
			checked = 0;
			foreach (mode_count[i]) mode_count[i] = 0;
		endfunction

		function void write_reg(reg_idx_t idx, bit [31:0] v);
			case (idx)
				REG_FIELD_K:  k_const = v[15:0];
				REG_IN_USE:   n_use = v[10:0];
				REG_TOP_FRAC: top_cut = v[15:0];
				REG_BOT_FRAC: bot_floor = v[15:0];
				default:      k_const = k_const;
			endcase
		endfunction

		function longint unsigned isqrt(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function longint unsigned field_term(longint unsigned ad, longint unsigned m);
			longint unsigned t;
			if (ad == 0) return 0;
			t = ((ad * k_const) << 24) / m;
			return (t << 12) / m;
		endfunction

		function longint unsigned pixel_field(bit [11:0] px, bit [11:0] py);
			longint unsigned sx;
			longint unsigned sy;
			longint unsigned ax;
			longint unsigned ay;
			longint unsigned m;
			longint unsigned a;
			longint unsigned s;
			int n;
			sx = 0;
			sy = 0;
			n = (n_use > MaxCharges) ? MaxCharges : int'(n_use);
			for (int k = 0; k < n; k++) begin
				ax = (px >= col_tab[k]) ? px - col_tab[k] : col_tab[k] - px;
				ay = (py >= row_tab[k]) ? py - row_tab[k] : row_tab[k] - py;
				m = isqrt((ax * ax + ay * ay) << 24) + 41;
				sx = sx + field_term(ax, m);
				if (sx > 64'hFFFF_FFFF) sx = 64'hFFFF_FFFF;
				sy = sy + field_term(ay, m);
				if (sy > 64'hFFFF_FFFF) sy = 64'hFFFF_FFFF;
			end
			a = sx * sx;
			s = a + sy * sy;
			// The sum of squares can wrap; that saturates the intensity.
			if (s < a) return 64'hFFFF_FFFF;
			a = isqrt(s);
			return (a > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a;
		endfunction

		function void note_input(pixel_word_t w);
			heat_word_t e;
			longint unsigned f;
			longint unsigned bot;
			longint unsigned top;
			longint unsigned lv;
			e = '{32'd0, 8'd0, 8'd0, 8'd0};
			mode_count[w.mode]++;
			case (w.mode)
				MODE_LOAD: begin
					col_tab[w.slot] = w.x;
					row_tab[w.slot] = w.y;
				end
				MODE_FRAME: peak = 0;
				MODE_MEASURE: begin
					f = pixel_field(w.x, w.y);
					if (f > peak) peak = f;
					e.intensity = f[31:0];
				end
				default: begin
					bot = (peak * bot_floor) >> 16;
					top = (peak * (65536 - top_cut)) >> 16;
					f = pixel_field(w.x, w.y);
					e.intensity = f[31:0];
					if (top > bot && f > bot) begin
						lv = (f - bot) * 1149 / (top - bot);
						if (lv <= 255) begin
							e.blue = lv[7:0];
						end else if (lv <= 510) begin
							e.green = 8'(lv - 255);
							e.blue = 8'd255;
						end else if (lv <= 765) begin
							e.red = 8'(lv - 510);
							e.green = 8'd255;
							e.blue = 8'(765 - lv);
						end else if (lv <= 1020) begin
							e.red = 8'd255;
							e.green = 8'(1020 - lv);
						end else if (lv <= 1149) begin
							e.red = 8'(1276 - lv);
						end else begin
							e.red = 8'd127;
						end
					end
				end
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(heat_word_t got);
			heat_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: result word with none expected: intensity %h rgb %h %h %h",
					$time, got.intensity, got.red, got.green, got.blue);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.intensity !== e.intensity) begin
				$display("%0t: intensity expected %h actual %h", $time, e.intensity,
					got.intensity);
				errors++;
			end
			if (got.red !== e.red) begin
				$display("%0t: red expected %h actual %h", $time, e.red, got.red);
				errors++;
			end
			if (got.green !== e.green) begin
				$display("%0t: green expected %h actual %h", $time, e.green, got.green);
				errors++;
			end
			if (got.blue !== e.blue) begin
				$display("%0t: blue expected %h actual %h", $time, e.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cfh_in_if  in_ch();
	cfh_out_if out_ch();

	charge_field_heatmap_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	heat_scoreboard sb = new();
	int cycles = 0;
	int burst_left = 0;
	bit bursty = 1;
	int stall_left = 0;
	int stall_mode = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout with %0d words outstanding", $time, sb.pending.size());
			$display("[charge_field_heatmap_top] ERROR");
			$finish;
		end
	end

	// The receiver ready is steady, random, mostly stalled or periodic in turn.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(40, 400);
			end
			stall_left--;
			case (stall_mode)
				0: out_ch.ready = 1'b1;
				1: out_ch.ready = ($urandom_range(0, 1) == 1);
				2: out_ch.ready = ($urandom_range(0, 7) == 0);
				default: out_ch.ready = ((cycles / 16) % 2 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		heat_word_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.intensity = out_ch.intensity;
			got.red = out_ch.red;
			got.green = out_ch.green;
			got.blue = out_ch.blue;
			sb.check_result(got);
		end
	end

	task automatic send_word(input mode_t md, input int unsigned slot,
		input int unsigned x, input int unsigned y);
		pixel_word_t w;
		if (bursty) begin
			if (burst_left == 0) begin
				@(negedge clk);
				in_ch.valid = 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.mode = md;
		in_ch.charge_slot = slot[9:0];
		in_ch.pos_x = x[11:0];
		in_ch.pos_y = y[11:0];
		do @(posedge clk); while (!in_ch.ready);
		w = '{md, slot[9:0], x[11:0], y[11:0]};
		sb.note_input(w);
	endtask

	// Drops valid and lets every outstanding word drain before a register write.
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		sb.write_reg(idx, v);
	endtask

	function automatic logic [15:0] pick_frac();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 40000));
		endcase
	endfunction

	initial begin
		int r;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_LOAD;
		in_ch.charge_slot = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with two charges at opposite corners.
		write_reg(REG_IN_USE, 32'd2);
		send_word(MODE_LOAD, 0, 0, 0);
		send_word(MODE_LOAD, 1, 'hFFF, 'hFFF);
		send_word(MODE_FRAME, 'h3FF, 'hFFF, 'hFFF);
		send_word(MODE_MEASURE, 0, 0, 0);
		send_word(MODE_MEASURE, 'h3FF, 'hFFF, 0);
		send_word(MODE_MEASURE, 5, 2048, 2048);
		send_word(MODE_MEASURE, 0, 'hFFF, 'hFFF);
		send_word(MODE_COLOR, 0, 2048, 2048);
		send_word(MODE_COLOR, 0, 0, 0);
		send_word(MODE_COLOR, 'h2AA, 'hFFF, 'hFFF);
		send_word(MODE_COLOR, 'h155, 1, 1);
		send_word(MODE_LOAD, 'h3FF, 'hFFF, 0);
		send_word(MODE_FRAME, 0, 0, 0);
		// Right after a frame start the peak is zero, so the pixel is black.
		send_word(MODE_COLOR, 0, 100, 3000);
		send_word(MODE_MEASURE, 0, 100, 3000);
		drain();
		write_reg(REG_FIELD_K, 32'd0);
		write_reg(REG_TOP_FRAC, 32'hFFFF);
		write_reg(REG_BOT_FRAC, 32'hFFFF);
		send_word(MODE_MEASURE, 0, 7, 9);
		send_word(MODE_COLOR, 0, 7, 9);

		// Fill the first eight slots so that every charge count used below is safe.
		for (int s = 0; s < 8; s++)
			send_word(MODE_LOAD, s, $urandom_range(0, 4095), $urandom_range(0, 4095));

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			bursty = (ph % 3 != 2);
			case (ph % 4)
				0: write_reg(REG_FIELD_K, 32'd1);
				1: write_reg(REG_FIELD_K, 32'hFFFF);
				default: write_reg(REG_FIELD_K, $urandom_range(1, 65535));
			endcase
			write_reg(REG_IN_USE, (ph == 5) ? 32'd0 : $urandom_range(1, 5));
			write_reg(REG_TOP_FRAC, {16'b0, pick_frac()});
			write_reg(REG_BOT_FRAC, (ph < 4) ? 32'd0 : {16'b0, pick_frac()});
			send_word(MODE_FRAME, $urandom_range(0, 1023), $urandom_range(0, 4095),
				$urandom_range(0, 4095));
			for (int i = 0; i < 42; i++) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					send_word(MODE_LOAD, $urandom_range(0, 1023), $urandom_range(0, 4095),
						$urandom_range(0, 4095));
				else if (r < 13)
					send_word(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
						$urandom_range(0, 4095), $urandom_range(0, 4095));
				else if ((i < 20) ? (r < 85) : (r < 35))
					send_word(MODE_MEASURE, $urandom_range(0, 1023),
						$urandom_range(0, 4095), $urandom_range(0, 4095));
				else
					send_word(MODE_COLOR, $urandom_range(0, 1023),
						$urandom_range(0, 4095), $urandom_range(0, 4095));
			end
		end

		// A last frame at the default scale over the eight filled slots.
		drain();
		write_reg(REG_FIELD_K, 32'd100);
		write_reg(REG_IN_USE, 32'd8);
		write_reg(REG_TOP_FRAC, 32'd6554);
		write_reg(REG_BOT_FRAC, 32'd0);
		send_word(MODE_FRAME, 0, 0, 0);
		send_word(MODE_MEASURE, 0, 2000, 2100);
		send_word(MODE_COLOR, 0, 300, 3900);
		drain();
		repeat (200) @(posedge clk);

		$display("Checked %0d result words: %0d loads, %0d measures, %0d colors, %0d frames.",
			sb.checked, sb.mode_count[0], sb.mode_count[1], sb.mode_count[2],
			sb.mode_count[3]);
		$display("Mismatches found: %0d.", sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[charge_field_heatmap_top] OK");
		end else begin
			$display("[charge_field_heatmap_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/cfh_pkg.sv
src/cfh_in_if.sv
src/cfh_out_if.sv
src/cfh_sqrt.sv
src/cfh_div.sv
src/cfh_dp.sv
src/cfh_ctrl.sv
src/charge_field_heatmap_top.sv
sim/charge_field_heatmap_top_tb.sv
